>>> src/gpd_pkg.sv
package gpd_pkg;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam int unsigned DIST_BITS = 31;
  localparam int unsigned ARG_BITS = 22;
  localparam int unsigned DDQ_BITS = 38;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_UNIT_DX  = 3'd3,
    REG_UNIT_DY  = 3'd4,
    REG_UNIT_DZ  = 3'd5,
    REG_DEPTH    = 3'd6,
    REG_FALLOFF  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic unity;
    logic kill;
  } gauss_flags_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] rem;
    r = '0;
    rem = v;
    bit_v = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= r + bit_v) begin
        rem = rem - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // 2^-(idx / 2^bits) in Q1.30
  function automatic logic [30:0] exp_table_entry(int idx, int bits);
    logic [63:0] e;
    logic [63:0] root;
    e = 64'(ONE_Q30);
    root = 64'(ONE_Q30) >> 1;
    for (int k = 1; k <= bits; k++) begin
      root = isqrt64(root << 30);
      if (((idx >> (bits - k)) & 1) != 0) begin
        e = (e * root + (64'(ONE_Q30) >> 1)) >> 30;
      end
    end
    return e[30:0];
  endfunction

endpackage

>>> src/gpd_in_if.sv
interface gpd_in_if #(
  parameter int COORD_BITS = 32
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] x_in;
  logic signed [COORD_BITS-1:0] y_in;
  logic signed [COORD_BITS-1:0] z_in;

  modport source(output valid, x_in, y_in, z_in, input ready);
  modport sink(input valid, x_in, y_in, z_in, output ready);
endinterface

>>> src/gpd_out_if.sv
interface gpd_out_if #(
  parameter int COORD_BITS = 32
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] x_out;
  logic signed [COORD_BITS-1:0] y_out;
  logic signed [COORD_BITS-1:0] z_out;

  modport source(output valid, x_out, y_out, z_out, input ready);
  modport sink(input valid, x_out, y_out, z_out, output ready);
endinterface

>>> src/gaussian_point_displacement_unit.sv
// channel   dir  transfer when        payload
// pt_in     in   valid && ready       x_in, y_in, z_in  signed Q16.16
// pt_out    out  valid && ready       x_out, y_out, z_out  signed Q16.16
// apb       in   psel&penable&pwrite  registers at 4*i (8*i above 32-bit coords)
// one point per cycle sustained while no result is held at pt_out
// pipeline: distance lanes, Gaussian stages (split falloff multiply, depth multiply), direction multiplies
// synchronous rst clears all pipeline valid bits; registers to 0, unit_dx/falloff to 1.0
// a held result stalls the whole pipeline; pt_in.ready drops only then
module gaussian_point_displacement_unit
  import gpd_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int EXP_TABLE_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  gpd_in_if.sink              pt_in,
  gpd_out_if.source           pt_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [((COORD_BITS > 32) ? 3 : 2)+2:0] paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                pready
);
  localparam int AS = (COORD_BITS > 32) ? 3 : 2;
  localparam int DW = (COORD_BITS > 32) ? 64 : 32;
  localparam int DIST_STAGES = 3;
  localparam int GAUSS_STAGES = 6;
  localparam int STAGES = DIST_STAGES + GAUSS_STAGES + 2;

  logic signed [COORD_BITS-1:0] center [3];
  logic signed [15:0] unit_d [3];
  logic signed [31:0] bump_depth;
  logic [31:0] falloff;
  reg_idx_t reg_idx;

  logic [STAGES-1:0] vld;
  logic adv;

  logic signed [COORD_BITS-1:0] coord [3];
  logic signed [COORD_BITS-1:0] coord_d [3];
  logic [2*DIST_BITS-1:0] dist_sq [3];
  logic signed [COORD_BITS-1:0] coord_dly [GAUSS_STAGES][3];
  logic signed [COORD_BITS-1:0] coord_res [3];
  logic signed [32:0] shift_q;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[AS+2:AS]);

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = DW'($unsigned(center[0]));
      REG_CENTER_Y: prdata = DW'($unsigned(center[1]));
      REG_CENTER_Z: prdata = DW'($unsigned(center[2]));
      REG_UNIT_DX:  prdata = DW'($unsigned(unit_d[0]));
      REG_UNIT_DY:  prdata = DW'($unsigned(unit_d[1]));
      REG_UNIT_DZ:  prdata = DW'($unsigned(unit_d[2]));
      REG_DEPTH:    prdata = DW'($unsigned(bump_depth));
      REG_FALLOFF:  prdata = DW'(falloff);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      unit_d[0] <= 16'sd16384;
      unit_d[1] <= '0;
      unit_d[2] <= '0;
      bump_depth <= '0;
      falloff <= 32'd65536;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CENTER_X: center[0] <= COORD_BITS'(pwdata);
        REG_CENTER_Y: center[1] <= COORD_BITS'(pwdata);
        REG_CENTER_Z: center[2] <= COORD_BITS'(pwdata);
        REG_UNIT_DX:  unit_d[0] <= pwdata[15:0];
        REG_UNIT_DY:  unit_d[1] <= pwdata[15:0];
        REG_UNIT_DZ:  unit_d[2] <= pwdata[15:0];
        REG_DEPTH:    bump_depth <= pwdata[31:0];
        REG_FALLOFF:  falloff <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  assign adv = !vld[STAGES-1] || pt_out.ready;
  assign pt_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], pt_in.valid};
    end
  end

  assign coord[0] = pt_in.x_in;
  assign coord[1] = pt_in.y_in;
  assign coord[2] = pt_in.z_in;

  for (genvar a = 0; a < 3; a++) begin : g_dist
    gpd_dist_lane #(.COORD_BITS(COORD_BITS)) u_dist (
      .clk     (clk),
      .en      (adv),
      .coord   (coord[a]),
      .center  (center[a]),
      .coord_d (coord_d[a]),
      .dist_sq (dist_sq[a])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coord_dly[0] <= coord_d;
      for (int s = 1; s < GAUSS_STAGES; s++) begin
        coord_dly[s] <= coord_dly[s-1];
      end
    end
  end

  gpd_gauss #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_gauss (
    .clk        (clk),
    .en         (adv),
    .sq_x       (dist_sq[0]),
    .sq_y       (dist_sq[1]),
    .sq_z       (dist_sq[2]),
    .falloff    (falloff),
    .bump_depth (bump_depth),
    .shift_q    (shift_q)
  );

  for (genvar a = 0; a < 3; a++) begin : g_apply
    gpd_apply_lane #(.COORD_BITS(COORD_BITS)) u_apply (
      .clk       (clk),
      .en        (adv),
      .coord     (coord_dly[GAUSS_STAGES-1][a]),
      .unit      (unit_d[a]),
      .shift_q   (shift_q),
      .coord_out (coord_res[a])
    );
  end

  assign pt_out.valid = vld[STAGES-1];
  assign pt_out.x_out = coord_res[0];
  assign pt_out.y_out = coord_res[1];
  assign pt_out.z_out = coord_res[2];

  ready_after_reset: assert property (@(posedge clk) $past(rst) && !rst |-> pt_in.ready)
    else $error("not ready after reset");
  stall_freezes: assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("pipeline moved during stall");
  result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(vld[STAGES-1]) |-> $past(vld[STAGES-2]))
    else $error("result without item in previous stage");
endmodule

>>> src/gpd_dist_lane.sv
module gpd_dist_lane
  import gpd_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] coord,
  input  logic signed [COORD_BITS-1:0] center,
  output logic signed [COORD_BITS-1:0] coord_d,
  output logic [2*DIST_BITS-1:0]       dist_sq
);
  localparam int DW = COORD_BITS + 1;
  localparam int EW = (DW > 32) ? DW : 32;
  localparam logic [EW-1:0] CAP = EW'(32'h7FFF_FFFF);

  logic signed [COORD_BITS-1:0] p1, p2;
  logic signed [DW-1:0] d1;
  logic [DIST_BITS-1:0] m2;
  logic [DW-1:0] mag;
  logic [EW-1:0] mag_ext;

  always_comb begin
    mag = d1[DW-1] ? DW'(-d1) : DW'(d1);
    mag_ext = EW'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= coord;
      d1 <= DW'(coord) - DW'(center);
      p2 <= p1;
      m2 <= (mag_ext > CAP) ? DIST_BITS'(CAP) : DIST_BITS'(mag_ext);
      coord_d <= p2;
      dist_sq <= m2 * m2;
    end
  end
endmodule

>>> src/gpd_gauss.sv
module gpd_gauss
  import gpd_pkg::*;
#(
  parameter int EXP_TABLE_BITS = 6
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2*DIST_BITS-1:0]  sq_x,
  input  logic [2*DIST_BITS-1:0]  sq_y,
  input  logic [2*DIST_BITS-1:0]  sq_z,
  input  logic [31:0]             falloff,
  input  logic signed [31:0]      bump_depth,
  output logic signed [32:0]      shift_q
);
  localparam int TBL_N = 2 ** EXP_TABLE_BITS;

  logic [TBL_N-1:0][30:0] exp_tbl;
  for (genvar i = 0; i < TBL_N; i++) begin : g_tbl
    assign exp_tbl[i] = exp_table_entry(i, EXP_TABLE_BITS);
  end

  logic [63:0] sq_sum;
  logic [47:0] ddq;
  logic [31:0] lo1;
  logic [DDQ_BITS-33:0] hi1;
  gauss_flags_t f1, f2, f3, f4;
  logic big1, big2;
  logic [63:0] pl2;
  logic [DDQ_BITS-1:0] ph2;
  logic [69:0] prod;
  logic [ARG_BITS-1:0] arg3;
  logic [38:0] yp;
  logic [ARG_BITS:0] y4;
  logic [6:0] n4;
  logic [EXP_TABLE_BITS-1:0] idx4;
  logic [30:0] e_next, e5;
  logic signed [63:0] dp6;

  always_comb begin
    sq_sum = 64'(sq_x) + 64'(sq_y) + 64'(sq_z);
    ddq = sq_sum[63:16];
    prod = {ph2, 32'b0} + 70'(pl2);
    yp = arg3 * LOG2E_Q16;
    n4 = y4[ARG_BITS:16];
    idx4 = y4[15 -: EXP_TABLE_BITS];
    if (f4.unity) begin
      e_next = ONE_Q30;
    end else if (f4.kill || n4 >= 7'd31) begin
      e_next = '0;
    end else begin
      e_next = exp_tbl[idx4] >> n4[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1.unity <= (falloff == '0) || (ddq == '0);
      f1.kill <= 1'b0;
      big1 <= ddq[47:DDQ_BITS] != '0;
      lo1 <= ddq[31:0];
      hi1 <= ddq[DDQ_BITS-1:32];

      f2 <= f1;
      big2 <= big1;
      pl2 <= lo1 * falloff;
      ph2 <= hi1 * falloff;

      f3.unity <= f2.unity;
      f3.kill <= big2 || (prod[69:DDQ_BITS] != '0);
      arg3 <= prod[DDQ_BITS-1:16];

      f4 <= f3;
      y4 <= yp[38:16];

      e5 <= e_next;

      dp6 <= bump_depth * $signed({1'b0, e5});
    end
  end

  assign shift_q = dp6[62:30];
endmodule

>>> src/gpd_apply_lane.sv
module gpd_apply_lane
  import gpd_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] coord,
  input  logic signed [15:0]           unit,
  input  logic signed [32:0]           shift_q,
  output logic signed [COORD_BITS-1:0] coord_out
);
  localparam int SW = ((COORD_BITS > 35) ? COORD_BITS : 35) + 1;
  localparam logic signed [SW-1:0] HI = (SW'(1) <<< (COORD_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] LO = -HI - SW'(1);

  logic signed [48:0] t1;
  logic signed [COORD_BITS-1:0] p1;
  logic signed [34:0] sh;
  logic signed [SW-1:0] sum;

  always_comb begin
    sh = t1[48:14];
    sum = SW'(p1) + SW'(sh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= unit * shift_q;
      p1 <= coord;
      if (sum > HI) begin
        coord_out <= COORD_BITS'(HI);
      end else if (sum < LO) begin
        coord_out <= COORD_BITS'(LO);
      end else begin
        coord_out <= COORD_BITS'(sum);
      end
    end
  end
endmodule
